@@ rtl/core/lpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types, constants and the saturation helper of the plateau stop detector.
// ----------------------------------------------------------------------------
package lpsd_pkg;

    localparam int VW        = 32;
    localparam int FB        = 16;
    localparam int DIV_BITS  = 53;
    localparam int CNT_W     = 6;
    localparam int PW        = 55;

    localparam logic signed [33:0] PI_Q     = 34'sd205887;
    localparam logic signed [33:0] TWO_PI_Q = 34'sd411774;
    localparam logic signed [20:0] USEC_PER_SEC = 21'sd1000000;
    localparam logic [16:0]        ONE_Q    = 17'd65536;

    localparam logic [1:0] ST_RECORD  = 2'd0;
    localparam logic [1:0] ST_PLATEAU = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [2:0] REG_EMA_ALPHA   = 3'd0;
    localparam logic [2:0] REG_GROWTH      = 3'd1;
    localparam logic [2:0] REG_MIN_FRAC    = 3'd2;
    localparam logic [2:0] REG_HOLD        = 3'd3;
    localparam logic [2:0] REG_STOP_THR    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT     = 3'd5;
    localparam logic [2:0] REG_ANGULAR     = 3'd6;
    localparam logic [2:0] REG_EARLY_EXIT  = 3'd7;

    typedef struct packed {
        logic [16:0] ema_alpha;
        logic [17:0] growth_factor;
        logic [16:0] min_fraction;
        logic [23:0] hold_time_us;
        logic [16:0] stop_threshold;
        logic [31:0] timeout_us;
        logic        angular_mode;
        logic        early_exit_enable;
    } t_cfg;

    typedef enum logic [4:0] {
        C_NONE, C_LOAD, C_HOLD, C_TIMEOUT, C_FIRST, C_UNWRAP, C_MUL_DIFF, C_RAW_PREV,
        C_DIV_START, C_DIV_STEP, C_DIV_END, C_SEED, C_EMA_A, C_EMA_B, C_EMA_SUM,
        C_GROW_MUL, C_GROW_CMP, C_FRAC_MUL, C_DECIDE, C_EMIT
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RATE, S_DIV_INIT, S_DIV, S_DIV_END, S_SEED, S_EMA_A,
        S_EMA_B, S_EMA_SUM, S_GROW_MUL, S_GROW_CMP, S_FRAC_MUL, S_DECIDE, S_EMIT
    } t_state;

    typedef struct packed {
        logic finished;
        logic timeout_hit;
        logic first;
        logic dt_gt1;
        logic div_last;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [VW-1:0] f_sat(input logic signed [PW:0] x);
        logic signed [PW:0] hi;
        logic signed [PW:0] lo;
        hi = (PW+1)'(signed'({1'b0, {(VW-1){1'b1}}}));
        lo = -hi - (PW+1)'(1);
        if (x > hi) begin
            return {1'b0, {(VW-1){1'b1}}};
        end else if (x < lo) begin
            return {1'b1, {(VW-1){1'b0}}};
        end
        return x[VW-1:0];
    endfunction

endpackage

@@ rtl/core/lpsd_cfg.sv @@
// ----------------------------------------------------------------------------
// lpsd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lpsd_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    output lpsd_pkg::t_cfg o_cfg
);
    import lpsd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ema_alpha         <= 17'd19661;
            r_cfg.growth_factor     <= 18'd66191;
            r_cfg.min_fraction      <= 17'd45875;
            r_cfg.hold_time_us      <= 24'd100000;
            r_cfg.stop_threshold    <= 17'd328;
            r_cfg.timeout_us        <= 32'd3000000;
            r_cfg.angular_mode      <= 1'b0;
            r_cfg.early_exit_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EMA_ALPHA:  r_cfg.ema_alpha         <= i_cfg_data[16:0];
                REG_GROWTH:     r_cfg.growth_factor     <= i_cfg_data[17:0];
                REG_MIN_FRAC:   r_cfg.min_fraction      <= i_cfg_data[16:0];
                REG_HOLD:       r_cfg.hold_time_us      <= i_cfg_data[23:0];
                REG_STOP_THR:   r_cfg.stop_threshold    <= i_cfg_data[16:0];
                REG_TIMEOUT:    r_cfg.timeout_us        <= i_cfg_data;
                REG_ANGULAR:    r_cfg.angular_mode      <= i_cfg_data[0];
                REG_EARLY_EXIT: r_cfg.early_exit_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/lpsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpsd_ctrl
// Sequencer: walks one word through check, unwrap, divide, filter and decide, or from check straight to emit.
// ----------------------------------------------------------------------------
module lpsd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  lpsd_pkg::t_dp_status i_sts,
    output lpsd_pkg::t_cmd       o_cmd
);
    import lpsd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NONE;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd   = C_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.finished) begin
                    o_cmd   = C_HOLD;
                    n_state = S_EMIT;
                end else if (i_sts.timeout_hit) begin
                    o_cmd   = C_TIMEOUT;
                    n_state = S_EMIT;
                end else if (i_sts.first) begin
                    o_cmd   = C_FIRST;
                    n_state = S_EMIT;
                end else begin
                    o_cmd   = C_UNWRAP;
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                if (i_sts.dt_gt1) begin
                    o_cmd   = C_MUL_DIFF;
                    n_state = S_DIV_INIT;
                end else begin
                    o_cmd   = C_RAW_PREV;
                    n_state = S_SEED;
                end
            end
            S_DIV_INIT: begin
                o_cmd   = C_DIV_START;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd = C_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd   = C_DIV_END;
                n_state = S_SEED;
            end
            S_SEED: begin
                o_cmd   = C_SEED;
                n_state = S_EMA_A;
            end
            S_EMA_A: begin
                o_cmd   = C_EMA_A;
                n_state = S_EMA_B;
            end
            S_EMA_B: begin
                o_cmd   = C_EMA_B;
                n_state = S_EMA_SUM;
            end
            S_EMA_SUM: begin
                o_cmd   = C_EMA_SUM;
                n_state = S_GROW_MUL;
            end
            S_GROW_MUL: begin
                o_cmd   = C_GROW_MUL;
                n_state = S_GROW_CMP;
            end
            S_GROW_CMP: begin
                o_cmd   = C_GROW_CMP;
                n_state = S_FRAC_MUL;
            end
            S_FRAC_MUL: begin
                o_cmd   = C_FRAC_MUL;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd   = C_DECIDE;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd   = C_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word taken while busy");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == C_EMIT) |-> i_sts.out_free)
        else $error("result loaded over unread result");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_DIV_END))
        else $error("divider did not finish");

endmodule

@@ rtl/core/lpsd_dp.sv @@
// ----------------------------------------------------------------------------
// lpsd_dp
// Datapath: state, shared multiplier, serial divider and result register.
// ----------------------------------------------------------------------------
module lpsd_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpsd_pkg::t_cmd        i_cmd,
    input  lpsd_pkg::t_cfg        i_cfg,
    input  logic                  i_start_req,
    input  logic [31:0]           i_sample_time_us,
    input  logic signed [31:0]    i_position,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic signed [31:0]    o_velocity,
    output logic signed [31:0]    o_unwrapped_position,
    output logic [1:0]            o_status,
    output lpsd_pkg::t_dp_status  o_sts
);
    import lpsd_pkg::*;

    logic               r_have_prev;
    logic               r_seeded;
    logic [31:0]        r_last_time;
    logic signed [31:0] r_last_pos;
    logic signed [31:0] r_last_vel;
    logic [31:0]        r_peak;
    logic [31:0]        r_lgt;
    logic signed [31:0] r_last_raw;
    logic signed [31:0] r_acc_head;
    logic [1:0]         r_finish;

    logic [31:0]        r_t;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_unw;
    logic signed [32:0] r_dt;
    logic signed [31:0] r_raw;
    logic signed [31:0] r_filt;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_acc;
    logic               r_neg;
    logic [DIV_BITS-1:0] r_quo;
    logic [31:0]        r_rem;
    logic [CNT_W-1:0]   r_cnt;

    logic signed [31:0] r_res_vel;
    logic signed [31:0] r_res_pos;
    logic [1:0]         r_res_st;
    logic               r_out_valid;
    logic signed [31:0] r_out_vel;
    logic signed [31:0] r_out_pos;
    logic [1:0]         r_out_st;

    logic [16:0]        alpha_sat;
    logic [16:0]        mf_sat;
    logic signed [33:0] delta;
    logic signed [33:0] delta_w;
    logic signed [31:0] acc_new;
    logic signed [31:0] unw_new;
    logic signed [33:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic [31:0]        absv;
    logic [PW-1:0]      absv_sh;
    logic [PW-1:0]      prod_u;
    logic signed [PW-1:0] prod_abs;
    logic [32:0]        trial;
    logic [33:0]        trial_d;
    logic               q_bit;
    logic signed [PW:0] quo_s;
    logic signed [PW:0] ema_s;
    logic               grow;
    logic signed [32:0] since;
    logic               plateau;

    assign alpha_sat = (i_cfg.ema_alpha > ONE_Q) ? ONE_Q : i_cfg.ema_alpha;
    assign mf_sat    = (i_cfg.min_fraction > ONE_Q) ? ONE_Q : i_cfg.min_fraction;

    always_comb begin
        delta = 34'(r_pos) - 34'(r_last_raw);
        if (delta > PI_Q) begin
            delta_w = delta - TWO_PI_Q;
        end else if (delta < -PI_Q) begin
            delta_w = delta + TWO_PI_Q;
        end else begin
            delta_w = delta;
        end
        acc_new = f_sat((PW+1)'(r_acc_head) + (PW+1)'(delta_w));
        unw_new = i_cfg.angular_mode ? acc_new : r_pos;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd)
            C_MUL_DIFF: begin
                mul_a = 34'(r_unw) - 34'(r_last_pos);
                mul_b = USEC_PER_SEC;
            end
            C_EMA_A: begin
                mul_a = 34'(r_raw);
                mul_b = 21'(signed'({1'b0, alpha_sat}));
            end
            C_EMA_B: begin
                mul_a = 34'(r_last_vel);
                mul_b = 21'(signed'({1'b0, ONE_Q - alpha_sat}));
            end
            C_GROW_MUL: begin
                mul_a = signed'({2'b00, r_peak});
                mul_b = 21'(signed'({1'b0, i_cfg.growth_factor}));
            end
            C_FRAC_MUL: begin
                mul_a = signed'({2'b00, r_peak});
                mul_b = 21'(signed'({1'b0, mf_sat}));
            end
            default: ;
        endcase
        mul_p = PW'(mul_a * mul_b);
    end

    assign absv     = r_filt[31] ? 32'(-r_filt) : 32'(r_filt);
    assign absv_sh  = PW'({absv, {FB{1'b0}}});
    assign prod_u   = unsigned'(r_prod);
    assign prod_abs = r_prod[PW-1] ? -r_prod : r_prod;

    assign trial   = {r_rem, r_quo[DIV_BITS-1]};
    assign trial_d = {1'b0, trial} - {2'b00, r_dt[31:0]};
    assign q_bit   = !trial_d[33];

    assign quo_s = r_neg ? -(PW+1)'({1'b0, r_quo}) : (PW+1)'({1'b0, r_quo});
    assign ema_s = ((PW+1)'(r_acc) + (PW+1)'(r_prod) + (PW+1)'(32768)) >>> FB;

    assign grow    = absv_sh > prod_u;
    assign since   = signed'({1'b0, r_t}) - signed'({1'b0, r_lgt});
    assign plateau = i_cfg.early_exit_enable && (absv_sh >= prod_u) &&
                     (since >= signed'({9'd0, i_cfg.hold_time_us})) &&
                     (r_peak > {15'd0, i_cfg.stop_threshold});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_seeded    <= 1'b0;
            r_last_time <= '0;
            r_last_pos  <= '0;
            r_last_vel  <= '0;
            r_peak      <= '0;
            r_lgt       <= '0;
            r_last_raw  <= '0;
            r_acc_head  <= '0;
            r_finish    <= ST_RECORD;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd == C_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                C_LOAD: begin
                    r_t   <= i_sample_time_us;
                    r_pos <= i_position;
                    if (i_start_req) begin
                        r_have_prev <= 1'b0;
                        r_seeded    <= 1'b0;
                        r_last_time <= '0;
                        r_last_pos  <= '0;
                        r_last_vel  <= '0;
                        r_peak      <= '0;
                        r_lgt       <= '0;
                        r_last_raw  <= '0;
                        r_acc_head  <= '0;
                        r_finish    <= ST_RECORD;
                    end
                end
                C_HOLD: begin
                    r_res_vel <= r_last_vel;
                    r_res_pos <= r_last_pos;
                    r_res_st  <= r_finish;
                end
                C_TIMEOUT: begin
                    r_finish  <= ST_TIMEOUT;
                    r_res_vel <= r_last_vel;
                    r_res_pos <= r_last_pos;
                    r_res_st  <= ST_TIMEOUT;
                end
                C_FIRST: begin
                    r_last_raw  <= r_pos;
                    r_acc_head  <= '0;
                    r_last_pos  <= i_cfg.angular_mode ? '0 : r_pos;
                    r_last_time <= r_t;
                    r_last_vel  <= '0;
                    r_have_prev <= 1'b1;
                    r_res_vel   <= '0;
                    r_res_pos   <= i_cfg.angular_mode ? '0 : r_pos;
                    r_res_st    <= r_finish;
                end
                C_UNWRAP: begin
                    r_acc_head <= acc_new;
                    r_last_raw <= r_pos;
                    r_unw      <= unw_new;
                    r_dt       <= signed'({1'b0, r_t}) - signed'({1'b0, r_last_time});
                end
                C_MUL_DIFF: r_prod <= mul_p;
                C_RAW_PREV: r_raw  <= r_last_vel;
                C_DIV_START: begin
                    r_neg <= r_prod[PW-1];
                    r_quo <= prod_abs[DIV_BITS-1:0];
                    r_rem <= '0;
                    r_cnt <= CNT_W'(DIV_BITS);
                end
                C_DIV_STEP: begin
                    r_rem <= q_bit ? trial_d[31:0] : trial[31:0];
                    r_quo <= {r_quo[DIV_BITS-2:0], q_bit};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                C_DIV_END: r_raw <= f_sat(quo_s);
                C_SEED: begin
                    if (!r_seeded) begin
                        r_last_vel <= r_raw;
                        r_peak     <= r_raw[31] ? 32'(-r_raw) : 32'(r_raw);
                        r_lgt      <= r_t;
                        r_seeded   <= 1'b1;
                    end
                end
                C_EMA_A:    r_acc  <= mul_p;
                C_EMA_B:    r_prod <= mul_p;
                C_EMA_SUM:  r_filt <= f_sat(ema_s);
                C_GROW_MUL: r_prod <= mul_p;
                C_GROW_CMP: begin
                    if (grow) begin
                        r_peak <= absv;
                        r_lgt  <= r_t;
                    end
                    r_last_time <= r_t;
                    r_last_pos  <= r_unw;
                    r_last_vel  <= r_filt;
                end
                C_FRAC_MUL: r_prod <= mul_p;
                C_DECIDE: begin
                    r_res_vel <= r_filt;
                    r_res_pos <= r_unw;
                    if (plateau) begin
                        r_finish <= ST_PLATEAU;
                        r_res_st <= ST_PLATEAU;
                    end else begin
                        r_res_st <= r_finish;
                    end
                end
                C_EMIT: begin
                    r_out_vel   <= r_res_vel;
                    r_out_pos   <= r_res_pos;
                    r_out_st    <= r_res_st;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.finished    = (r_finish != ST_RECORD);
        o_sts.timeout_hit = (r_t >= i_cfg.timeout_us);
        o_sts.first       = !r_have_prev;
        o_sts.dt_gt1      = (r_dt > 33'sd1);
        o_sts.div_last    = (r_cnt == CNT_W'(1));
        o_sts.out_free    = !r_out_valid || i_ready;
    end

    assign o_valid              = r_out_valid;
    assign o_velocity           = r_out_vel;
    assign o_unwrapped_position = r_out_pos;
    assign o_status             = r_out_st;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_RECORD || o_status == ST_PLATEAU ||
                     o_status == ST_TIMEOUT))
        else $error("bad status code");

    a_finish_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finish != ST_RECORD && i_cmd != C_LOAD) |=> (r_finish == $past(r_finish)))
        else $error("finish status changed without start");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == C_DIV_STEP) |=> ({1'b0, r_rem} < r_dt))
        else $error("divider remainder out of range");

endmodule

@@ rtl/core/live_plateau_stop_detector.sv @@
// ----------------------------------------------------------------------------
// live_plateau_stop_detector
// Velocity estimator with peak tracking and plateau/timeout stop decision.
// ----------------------------------------------------------------------------
// One word at a time. A word that ends early (latched finish, timeout or the
// first sample) goes from the check straight to the output register; a regular
// sample passes the 53-step serial divider for the raw velocity (skipped when
// the time step is 1 us or less), the filter and the decision. The sequencer
// is idle again in the cycle after loading the result, so no new word is
// taken before then. While an earlier result is still unread, the sequencer
// waits before loading the output register and no new word is taken.
module live_plateau_stop_detector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_start_req,
    input  logic [31:0]        i_sample_time_us,
    input  logic signed [31:0] i_position,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_unwrapped_position,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import lpsd_pkg::*;

    t_cfg       cfg;
    t_cmd       cmd;
    t_dp_status sts;

    lpsd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lpsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lpsd_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_cfg                (cfg),
        .i_start_req          (i_start_req),
        .i_sample_time_us     (i_sample_time_us),
        .i_position           (i_position),
        .i_ready              (i_ready),
        .o_valid              (o_valid),
        .o_velocity           (o_velocity),
        .o_unwrapped_position (o_unwrapped_position),
        .o_status             (o_status),
        .o_sts                (sts)
    );

endmodule
